// ===== rtl/chd_pkg.sv =====
// Shared types, codes and the CRC-32 byte update for the canonical Huffman decoder.
package chd_pkg;

    localparam int NUM_SYMBOLS   = 256;
    localparam int MAX_CODE_BITS = 15;
    localparam int BUF_W         = 23;
    localparam int CNT_W         = 5;
    localparam int LEN_W         = 4;
    localparam int ROW_CNT_W     = 9;
    localparam int CFG_INDEX_W   = 8;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef enum logic [1:0] {
        OP_ROW    = 2'd0,
        OP_SLOT   = 2'd1,
        OP_BYTE   = 2'd2,
        OP_FINISH = 2'd3
    } chd_op_t;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_MORE_OUTPUT = 2'd1;
    localparam logic [1:0] ST_VERIFY_ERR  = 2'd2;

    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_END    = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LIMIT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_SEED     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERIFY_ONLY  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_CRC = 8'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTE_CHK,
        S_MATCH,
        S_READ,
        S_COMMIT,
        S_FIN_CHK,
        S_FIN_END,
        S_HALT_END,
        S_FLUSH
    } chd_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic set_halt;
        logic match;
        logic read;
        logic commit;
        logic push_end;
        logic restart;
        logic flush;
    } chd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic halted;
        logic ge_code;
        logic count_nz;
        logic limit_hit;
        logic emit_sym;
        logic pend_valid;
        logic out_free;
    } chd_stat_t;

    // Reflected CRC-32 over one byte, inverted before and after
    function automatic logic [31:0] crc_add(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = ~c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return ~x;
    endfunction

endpackage

// ===== rtl/chd_ctrl.sv =====
// Controller state machine sequencing loads, code matching and result delivery.
module chd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic [1:0]          s_tuser,
    output logic                s_tready,
    input  chd_pkg::chd_stat_t  stat,
    output chd_pkg::chd_cmd_t   cmd
);
    import chd_pkg::*;

    chd_state_t state_reg, state_next;
    logic       fin_reg, fin_next;
    logic       acc;

    // State register and loop mode
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    cmd.accept = 1'b1;
                    unique case (chd_op_t'(s_tuser))
                        OP_BYTE: begin
                            fin_next = 1'b0;
                            if (!stat.halted)
                                state_next = S_BYTE_CHK;
                        end
                        OP_FINISH: begin
                            fin_next   = 1'b1;
                            state_next = S_FIN_CHK;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_BYTE_CHK: begin
                if (!stat.ge_code)
                    state_next = S_FLUSH;
                else if (stat.limit_hit)
                    state_next = S_HALT_END;
                else
                    state_next = S_MATCH;
            end
            S_MATCH: begin
                cmd.match  = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // hold while a symbol is due and both result registers are full
                if (!(stat.emit_sym && stat.pend_valid && !stat.out_free)) begin
                    cmd.commit = 1'b1;
                    state_next = fin_reg ? S_FIN_CHK : S_BYTE_CHK;
                end
            end
            S_FIN_CHK: begin
                if (stat.halted || !stat.count_nz) begin
                    state_next = S_FIN_END;
                end else if (stat.limit_hit) begin
                    cmd.set_halt = 1'b1;
                    state_next   = S_FIN_END;
                end else begin
                    state_next = S_MATCH;
                end
            end
            S_FIN_END: begin
                // push the end status and start a new stream
                if (!stat.pend_valid || stat.out_free) begin
                    cmd.push_end = 1'b1;
                    cmd.restart  = 1'b1;
                    state_next   = S_FLUSH;
                end
            end
            S_HALT_END: begin
                if (!stat.pend_valid || stat.out_free) begin
                    cmd.push_end = 1'b1;
                    cmd.set_halt = 1'b1;
                    state_next   = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/chd_datapath.sv =====
// Datapath: code tables, bit buffer, canonical matcher, CRC and result registers.
module chd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    s_tuser,
    input  logic [63:0]                   s_tdata,
    input  logic                          cfg_valid,
    input  logic [chd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  chd_pkg::chd_cmd_t             cmd,
    output chd_pkg::chd_stat_t            stat
);
    import chd_pkg::*;

    // Input fields
    logic [3:0]  in_len;
    logic [14:0] in_first_code;
    logic [8:0]  in_count;
    logic [7:0]  in_first_slot;
    logic [7:0]  in_slot_index;
    logic [7:0]  in_slot_symbol;
    logic [7:0]  in_byte;
    logic [3:0]  in_valid_bits;

    assign in_len         = s_tdata[3:0];
    assign in_first_code  = s_tdata[18:4];
    assign in_count       = s_tdata[27:19];
    assign in_first_slot  = s_tdata[35:28];
    assign in_slot_index  = s_tdata[43:36];
    assign in_slot_symbol = s_tdata[51:44];
    assign in_byte        = s_tdata[59:52];
    assign in_valid_bits  = s_tdata[63:60];

    // Configuration
    logic [31:0] limit_reg, seed_reg, expect_reg;
    logic        verify_reg;

    // Code tables
    logic [14:0]          first_code_mem [MAX_CODE_BITS];
    logic [7:0]           first_slot_mem [MAX_CODE_BITS];
    logic [ROW_CNT_W-1:0] count_reg      [MAX_CODE_BITS];
    logic [7:0]           slot_mem       [NUM_SYMBOLS];

    // Stream state
    logic [BUF_W-1:0] buf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      crc_reg;
    logic [31:0]      emitted_reg;
    logic             halted_reg;

    // Match results
    logic             found_reg;
    logic [LEN_W-1:0] len_reg;
    logic [7:0]       addr_reg;
    logic [7:0]       sym_reg;

    // Result registers: pending stage and output stage
    logic        pend_valid_reg, out_valid_reg;
    logic        pend_kind_reg, out_kind_reg, out_last_reg;
    logic [7:0]  pend_sym_reg, out_sym_reg;
    logic [31:0] pend_crc_reg, out_crc_reg;
    logic [1:0]  pend_status_reg, out_status_reg;

    logic        out_free;
    logic        limit_hit;
    logic [31:0] crc_new;
    logic [1:0]  end_status;
    logic [3:0]  vb_clip;
    logic [7:0]  byte_masked;
    logic [CNT_W-1:0] drop_len;
    logic [14:0] rev;
    logic        m_found;
    logic [LEN_W-1:0] m_len;
    logic [7:0]  m_addr;
    logic        push_sym;
    logic        push_any;

    assign out_free  = !out_valid_reg || m_tready;
    assign limit_hit = !verify_reg && (emitted_reg >= limit_reg);
    assign crc_new   = crc_add(crc_reg, sym_reg);
    assign vb_clip   = (in_valid_bits > 4'd8) ? 4'd8 : in_valid_bits;
    assign byte_masked = in_byte & ~(8'hFF << vb_clip);

    // Status back to the controller
    assign stat.halted     = halted_reg;
    assign stat.ge_code    = (cnt_reg >= CNT_W'(MAX_CODE_BITS));
    assign stat.count_nz   = (cnt_reg != '0);
    assign stat.limit_hit  = limit_hit;
    assign stat.emit_sym   = found_reg && !verify_reg;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    // Canonical match over all lengths; shortest hit wins
    always_comb begin
        logic [14:0] code;
        logic [15:0] diff;
        for (int k = 0; k < MAX_CODE_BITS; k++) begin
            rev[MAX_CODE_BITS-1-k] = buf_reg[k];
        end
        m_found = 1'b0;
        m_len   = '0;
        m_addr  = '0;
        for (int l = MAX_CODE_BITS; l >= 1; l--) begin
            code = rev >> (MAX_CODE_BITS - l);
            diff = {1'b0, code} - {1'b0, first_code_mem[l-1]};
            if (count_reg[l-1] != '0 && !diff[15] && (diff < {7'd0, count_reg[l-1]})) begin
                m_found = 1'b1;
                m_len   = LEN_W'(l);
                m_addr  = first_slot_mem[l-1] + diff[7:0];
            end
        end
    end

    // Bits consumed by a commit, never more than buffered
    always_comb begin
        logic [CNT_W-1:0] want;
        want     = found_reg ? CNT_W'(len_reg) : CNT_W'(MAX_CODE_BITS);
        drop_len = (want > cnt_reg) ? cnt_reg : want;
    end

    assign end_status = (halted_reg || cmd.set_halt) ? ST_MORE_OUTPUT :
                        (verify_reg && crc_reg != expect_reg) ? ST_VERIFY_ERR : ST_OK;

    assign push_sym = cmd.commit && found_reg && !verify_reg;
    assign push_any = push_sym || cmd.push_end;

    // Configuration and stream state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit_reg   <= 32'hFFFF_FFFF;
            seed_reg    <= '0;
            verify_reg  <= 1'b0;
            expect_reg  <= '0;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            crc_reg     <= '0;
            emitted_reg <= '0;
            halted_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_OUTPUT_LIMIT: limit_reg <= cfg_data;
                    CFG_CRC_SEED: begin
                        seed_reg <= cfg_data;
                        crc_reg  <= cfg_data;
                    end
                    CFG_VERIFY_ONLY:  verify_reg <= cfg_data[0];
                    CFG_EXPECTED_CRC: expect_reg <= cfg_data;
                    default: ;
                endcase
            end
            // append byte bits above those already held
            if (cmd.accept && chd_op_t'(s_tuser) == OP_BYTE && !halted_reg) begin
                buf_reg <= buf_reg | (BUF_W'(byte_masked) << cnt_reg);
                cnt_reg <= cnt_reg + CNT_W'(vb_clip);
            end
            if (cmd.set_halt)
                halted_reg <= 1'b1;
            if (cmd.commit) begin
                buf_reg <= buf_reg >> drop_len;
                cnt_reg <= cnt_reg - drop_len;
                if (found_reg) begin
                    crc_reg <= crc_new;
                    if (!verify_reg)
                        emitted_reg <= emitted_reg + 32'd1;
                end
            end
            // finish starts a new stream
            if (cmd.restart) begin
                buf_reg     <= '0;
                cnt_reg     <= '0;
                crc_reg     <= seed_reg;
                emitted_reg <= '0;
                halted_reg  <= 1'b0;
            end
        end
    end

    // Row count table, cleared at reset
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_CODE_BITS; i++)
                count_reg[i] <= '0;
        end else if (cmd.accept && chd_op_t'(s_tuser) == OP_ROW
                     && in_len >= 4'd1 && in_len <= 4'(MAX_CODE_BITS)) begin
            count_reg[in_len - 4'd1] <= (in_count > 9'(NUM_SYMBOLS)) ? 9'(NUM_SYMBOLS)
                                                                       : in_count;
        end
    end

    // Row first code and first slot
    always_ff @(posedge clk) begin
        if (cmd.accept && chd_op_t'(s_tuser) == OP_ROW
            && in_len >= 4'd1 && in_len <= 4'(MAX_CODE_BITS)) begin
            first_code_mem[in_len - 4'd1] <= in_first_code;
            first_slot_mem[in_len - 4'd1] <= in_first_slot;
        end
    end

    // Slot table memory with registered read
    always_ff @(posedge clk) begin
        if (cmd.accept && chd_op_t'(s_tuser) == OP_SLOT)
            slot_mem[in_slot_index] <= in_slot_symbol;
        if (cmd.read)
            sym_reg <= slot_mem[addr_reg];
    end

    // Match registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            found_reg <= 1'b0;
        end else if (cmd.match) begin
            found_reg <= m_found;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.match) begin
            len_reg  <= m_len;
            addr_reg <= m_addr;
        end
    end

    // Pending and output result registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (m_tready)
                out_valid_reg <= 1'b0;
            if (push_any) begin
                if (pend_valid_reg)
                    out_valid_reg <= 1'b1;
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if ((push_any && pend_valid_reg) || cmd.flush) begin
            out_kind_reg   <= pend_kind_reg;
            out_sym_reg    <= pend_sym_reg;
            out_crc_reg    <= pend_crc_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= cmd.flush;
        end
        if (push_sym) begin
            pend_kind_reg   <= KIND_SYMBOL;
            pend_sym_reg    <= sym_reg;
            pend_crc_reg    <= crc_new;
            pend_status_reg <= ST_OK;
        end else if (cmd.push_end) begin
            pend_kind_reg   <= KIND_END;
            pend_sym_reg    <= '0;
            pend_crc_reg    <= crc_reg;
            pend_status_reg <= end_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_crc_reg, out_sym_reg};

endmodule

// ===== rtl/canonical_huffman_decoder_crc.sv =====
// Top level of the canonical Huffman literal decoder with running CRC-32.
// Load items (length rows, symbol slots) are taken in the idle state. A
// compressed byte passes through accept, buffer check and result flush,
// plus match, slot-table read, commit and buffer check for each code it
// completes; a finish item passes through accept, then match, slot-table
// read, commit and check for each remaining code, then check, push and
// flush of the end status. The sequencer handles one item at a time; the
// registered slot-table read lies between matching and CRC update. A result
// waits in an output register while the next code is decoded, so decoding
// stalls only when two results are waiting. Symbol results carry the CRC
// after that symbol; the end status closes each stream.
module canonical_huffman_decoder_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row_length, row_first_code, row_count, row_first_slot, slot_index,
    // slot_symbol, data_byte, valid_bits
    input  logic [63:0] s_tdata,
    // operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // symbol, crc, status, zero fill
    output logic [47:0] m_tdata,
    // kind
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [chd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import chd_pkg::*;

    chd_cmd_t  cmd;
    chd_stat_t stat;

    assign cfg_ready = 1'b1;

    chd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== rtl/chd_checker.sv =====
// Port-level checks on the decoder's result stream, bound to the top level.
module chd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import chd_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // An end status always closes the item's results
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_END |-> m_tlast)
        else $error("end status not marked last");

    // Symbols carry an ok status
    a_sym_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_SYMBOL |-> m_tdata[41:40] == ST_OK)
        else $error("symbol with non-ok status");

    // End status has a zero symbol and a defined status code
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_END |-> m_tdata[7:0] == 8'd0
            && (m_tdata[41:40] == ST_OK || m_tdata[41:40] == ST_MORE_OUTPUT
                || m_tdata[41:40] == ST_VERIFY_ERR))
        else $error("malformed end status");

endmodule

bind canonical_huffman_decoder_crc chd_checker u_chd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the canonical Huffman decoder: queued stream driver, monitor, predictor.
`timescale 1ns / 1ps

module tb_top;
    import chd_pkg::*;

    localparam int QUIET_CYCLES = 160;
    localparam int SLOT_WIN     = 16;

    typedef struct {
        bit          is_cfg;
        logic [7:0]  idx;
        logic [31:0] val;
        logic [1:0]  op;
        logic [63:0] data;
    } pend_item_t;

    typedef struct {
        logic        kind;
        logic [7:0]  symbol;
        logic [31:0] crc;
        logic [1:0]  status;
        logic        last;
    } dec_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    canonical_huffman_decoder_crc dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor state
    logic [31:0] lim_reg, seed_reg, exp_crc_reg;
    logic        verify_reg;
    logic [31:0] bitbuf;
    int unsigned nbits;
    logic [14:0] row_code [15];
    int unsigned row_cnt [15];
    logic [7:0]  row_slot [15];
    logic [7:0]  slot_sym [256];
    logic [31:0] crc_run;
    logic [31:0] sym_count;
    bit          stopped;

    pend_item_t  pend_q[$];
    dec_result_t expected_q[$];
    dec_result_t step_q[$];
    pend_item_t  cur;
    int          fails;
    int          gap_left;
    int          rgap_left;
    int          quiet;
    int          sent_items;
    int          out_seen;
    int          hold_cnt;
    bit          hold_done;
    bit          nvalid, ncfg;

    // Byte-wise reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = ~c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
        return ~x;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((sent_items % 48) < 12) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic drop_bits(input int unsigned n);
        if (n > nbits) n = nbits;
        bitbuf = bitbuf >> n;
        nbits -= n;
    endtask

    task automatic push_res(input logic k, input logic [7:0] s, input logic [31:0] c,
                            input logic [1:0] st);
        dec_result_t r;
        r.kind = k; r.symbol = s; r.crc = c; r.status = st; r.last = 1'b0;
        step_q.push_back(r);
    endtask

    // Match one canonical code, shortest length first
    task automatic decode_code();
        logic [31:0] code;
        logic [31:0] off;
        logic [7:0]  s;
        code = 0;
        for (int l = 1; l <= MAX_CODE_BITS; l++) begin
            code = (code << 1) | ((bitbuf >> (l - 1)) & 32'd1);
            off = code - {17'd0, row_code[l-1]};
            if (row_cnt[l-1] != 0 && off < row_cnt[l-1]) begin
                s = slot_sym[(row_slot[l-1] + off[7:0]) & 8'hFF];
                drop_bits(l);
                crc_run = crc_byte(crc_run, s);
                if (!verify_reg) begin
                    push_res(KIND_SYMBOL, s, crc_run, ST_OK);
                    sym_count++;
                end
                return;
            end
        end
        drop_bits(MAX_CODE_BITS);
    endtask

    task automatic restart_stream();
        bitbuf = 0; nbits = 0; sym_count = 0; stopped = 0; crc_run = seed_reg;
    endtask

    task automatic predict_item(input logic [1:0] op, input logic [63:0] d);
        int unsigned len, cnt, vb;
        logic [1:0] st;
        step_q.delete();
        case (op)
            OP_ROW: begin
                len = d[3:0];
                cnt = d[27:19];
                if (len >= 1 && len <= MAX_CODE_BITS) begin
                    if (cnt > NUM_SYMBOLS) cnt = NUM_SYMBOLS;
                    row_code[len-1] = d[18:4];
                    row_cnt[len-1]  = cnt;
                    row_slot[len-1] = d[35:28];
                end
            end
            OP_SLOT: slot_sym[d[43:36]] = d[51:44];
            OP_BYTE: begin
                vb = d[63:60];
                if (!stopped) begin
                    if (vb > 8) vb = 8;
                    bitbuf = bitbuf | ((({24'd0, d[59:52]}) & ((32'd1 << vb) - 1)) << nbits);
                    nbits += vb;
                    while (nbits >= MAX_CODE_BITS) begin
                        if (!verify_reg && sym_count >= lim_reg) begin
                            stopped = 1;
                            push_res(KIND_END, 8'd0, crc_run, ST_MORE_OUTPUT);
                            break;
                        end
                        decode_code();
                    end
                end
            end
            default: begin
                st = ST_OK;
                if (stopped) st = ST_MORE_OUTPUT;
                else begin
                    while (nbits > 0) begin
                        if (!verify_reg && sym_count >= lim_reg) begin
                            st = ST_MORE_OUTPUT;
                            break;
                        end
                        decode_code();
                    end
                end
                if (verify_reg && st == ST_OK && crc_run != exp_crc_reg) st = ST_VERIFY_ERR;
                push_res(KIND_END, 8'd0, crc_run, st);
                restart_stream();
            end
        endcase
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endtask

    task automatic apply_cfg(input logic [7:0] idx, input logic [31:0] v);
        case (idx)
            CFG_OUTPUT_LIMIT: lim_reg = v;
            CFG_CRC_SEED:     begin seed_reg = v; crc_run = v; end
            CFG_VERIFY_ONLY:  verify_reg = v[0];
            CFG_EXPECTED_CRC: exp_crc_reg = v;
            default: ;
        endcase
    endtask

    // Queue builders
    task automatic q_cfg(input logic [7:0] idx, input logic [31:0] v);
        pend_item_t p;
        p = '{default: '0};
        p.is_cfg = 1; p.idx = idx; p.val = v;
        pend_q.push_back(p);
    endtask

    task automatic q_item(input logic [1:0] op, input logic [63:0] d);
        pend_item_t p;
        p = '{default: '0};
        p.op = op; p.data = d;
        pend_q.push_back(p);
    endtask

    task automatic q_row(input logic [3:0] l, input logic [14:0] fc, input logic [8:0] c,
                         input logic [7:0] fs);
        q_item(OP_ROW, {28'd0, fs, c, fc, l});
    endtask

    task automatic q_slot(input logic [7:0] i, input logic [7:0] s);
        q_item(OP_SLOT, {12'd0, s, i, 36'd0});
    endtask

    task automatic q_byte(input logic [7:0] b, input logic [3:0] vb);
        q_item(OP_BYTE, {vb, b, 52'd0});
    endtask

    // Build a random prefix-free canonical code over all 15 lengths,
    // drawing its symbols from the low slots only
    task automatic q_code(input bit one_bit);
        logic [31:0] fc;
        int c, avail, slot, room;
        fc = 0; slot = 0;
        for (int l = 1; l <= MAX_CODE_BITS; l++) begin
            avail = (1 << l) - fc;
            room  = SLOT_WIN - slot;
            c = 0;
            if (one_bit) c = (l == 1) ? 2 : 0;
            else if (avail > 0 && room > 0 && $urandom_range(0, 2) == 0)
                c = $urandom_range(1, (avail < room) ? avail : room);
            q_row(4'(l), fc[14:0], 9'(c), 8'(slot));
            slot = slot + c;
            fc = (fc + c) << 1;
        end
    endtask

    task automatic q_stream(input int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0)
                q_byte(8'($urandom), 4'($urandom_range(0, 15)));
            else
                q_byte(8'($urandom), 4'((i == nbytes - 1) ? $urandom_range(1, 8) : 8));
        end
        q_item(OP_FINISH, {$urandom, $urandom});
    endtask

    // Clock
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Driver: offer pending items, write registers only when quiet
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                predict_item(cur.op, cur.data);
                sent_items++;
            end
            if (cfg_valid && cfg_ready) apply_cfg(cur.idx, cur.val);
            nvalid = s_tvalid && !s_tready;
            ncfg   = cfg_valid && !cfg_ready;
            if (expected_q.size() != 0 || m_tvalid || nvalid || s_tvalid) quiet = 0;
            else quiet++;
            if (!nvalid && !ncfg) begin
                if (gap_left > 0) gap_left--;
                else if (pend_q.size() > 0) begin
                    if (!pend_q[0].is_cfg) begin
                        cur = pend_q.pop_front();
                        nvalid = 1;
                        gap_left = pick_gap();
                    end
                    else if (quiet >= QUIET_CYCLES) begin
                        cur = pend_q.pop_front();
                        ncfg = 1;
                    end
                end
            end
            s_tvalid  <= nvalid;
            s_tdata   <= cur.data;
            s_tuser   <= cur.op;
            cfg_valid <= ncfg;
            cfg_index <= cur.idx;
            cfg_data  <= cur.val;
        end
    end

    // Long receiver hold-off, once, so the block backs up into its input
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 0;
        end
        else if (!hold_done && out_seen >= 30) begin
            hold_cnt  <= 400;
            hold_done <= 1;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // Monitor: check each result against the oldest expectation
    always @(posedge clk or negedge rst_n) begin
        dec_result_t e;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                out_seen++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result: kind %0d data %h", m_tuser, m_tdata);
                    fails++;
                end
                else begin
                    e = expected_q.pop_front();
                    if (m_tuser !== e.kind) begin
                        $error("kind: expected %0d actual %0d", e.kind, m_tuser); fails++;
                    end
                    if (m_tdata[7:0] !== e.symbol) begin
                        $error("symbol: expected %h actual %h", e.symbol, m_tdata[7:0]);
                        fails++;
                    end
                    if (m_tdata[39:8] !== e.crc) begin
                        $error("crc: expected %h actual %h", e.crc, m_tdata[39:8]); fails++;
                    end
                    if (m_tdata[41:40] !== e.status) begin
                        $error("status: expected %0d actual %0d", e.status, m_tdata[41:40]);
                        fails++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last: expected %0d actual %0d", e.last, m_tlast); fails++;
                    end
                end
            end
            if (rgap_left > 0) rgap_left--;
            else rgap_left = pick_gap();
            m_tready <= (hold_cnt == 0) && (rgap_left == 0);
        end
    end

    // Timeout
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        logic [31:0] sd;
        int          fs;
        fails = 0; gap_left = 0; rgap_left = 0; quiet = 0; sent_items = 0; out_seen = 0;
        cur = '{default: '0};
        lim_reg = 32'hFFFFFFFF; seed_reg = 0; verify_reg = 0; exp_crc_reg = 0;
        for (int i = 0; i < 15; i++) begin
            row_code[i] = 0; row_cnt[i] = 0; row_slot[i] = 0;
        end
        for (int i = 0; i < 256; i++) slot_sym[i] = 0;
        restart_stream();
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // Fill the low slots that the generated codes draw from
        for (int i = 0; i < SLOT_WIN; i++) q_slot(8'(i), 8'($urandom));

        // Directed: defaults, field extremes and the named corner cases
        q_cfg(CFG_OUTPUT_LIMIT, 32'hFFFFFFFF);
        q_cfg(CFG_CRC_SEED, 32'h0);
        q_cfg(CFG_VERIFY_ONLY, 32'h0);
        q_cfg(CFG_EXPECTED_CRC, 32'h0);
        q_row(4'd0, 15'h7FFF, 9'h1FF, 8'hFF);           // length zero: ignored
        q_code(1);                                       // one-bit codes: eight symbols a byte
        q_row(4'd1, 15'h0, 9'd2, 8'hFF);                 // slot index wraps past the top
        q_row(4'd2, 15'h0, 9'd0, 8'd0);
        q_row(4'd15, 15'h7FFF, 9'h1FF, 8'hFF);          // count saturates
        q_slot(8'hFF, 8'hFF);
        q_slot(8'h00, 8'h00);
        q_byte(8'hFF, 4'd8);
        q_byte(8'h00, 4'd8);
        q_byte(8'hA5, 4'd0);                             // no bits added
        q_byte(8'h5A, 4'd15);                            // counts as eight
        q_byte(8'h3C, 4'd7);
        q_item(OP_FINISH, '0);
        q_item(OP_FINISH, '1);                           // empty stream
        q_row(4'd1, 15'h7FFF, 9'd1, 8'd0);               // one-bit row matches nothing
        q_byte(8'hFF, 4'd8);
        q_byte(8'hFF, 4'd8);
        q_item(OP_FINISH, '0);

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            sd = $urandom;
            case (ph)
                1: begin q_cfg(CFG_OUTPUT_LIMIT, 3); q_cfg(CFG_CRC_SEED, 32'hFFFFFFFF); end
                2: q_cfg(CFG_OUTPUT_LIMIT, 0);
                3: begin q_cfg(CFG_VERIFY_ONLY, 1); q_cfg(CFG_EXPECTED_CRC, $urandom); end
                4: begin q_cfg(CFG_CRC_SEED, sd); q_cfg(CFG_EXPECTED_CRC, sd); end
                5: begin
                    q_cfg(CFG_VERIFY_ONLY, 0); q_cfg(CFG_OUTPUT_LIMIT, $urandom_range(1, 12));
                    q_cfg(CFG_CRC_SEED, $urandom);
                end
                default: q_cfg(CFG_OUTPUT_LIMIT, 32'hFFFFFFFF);
            endcase
            q_code(ph == 2);
            if (ph == 4) q_item(OP_FINISH, '0);          // verify match on an empty stream
            for (int s = 0; s < 2; s++) begin
                if ($urandom_range(0, 4) == 0) q_slot(8'($urandom), 8'($urandom));
                if ($urandom_range(0, 6) == 0) begin
                    fs = $urandom_range(0, SLOT_WIN - 1);
                    q_row(4'($urandom_range(0, 15)), 15'($urandom),
                          9'($urandom_range(0, SLOT_WIN - fs)), 8'(fs));
                end
                q_stream($urandom_range(1, 3));
            end
        end

        // Drain: all items sent, all results seen, then a quiet tail
        while (pend_q.size() > 0 || s_tvalid || cfg_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (fails == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== canonical_huffman_decoder_crc.f =====
rtl/chd_pkg.sv
rtl/chd_ctrl.sv
rtl/chd_datapath.sv
rtl/canonical_huffman_decoder_crc.sv
rtl/chd_checker.sv
bench/tb_top.sv
